### rtl/integer_calculator_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer calculator unit
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef INTEGER_CALCULATOR_UNIT_ASSERT_SVH
`define INTEGER_CALCULATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// expr holds at every edge
`define ICU_ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// ante implies cons in the same cycle
`define ICU_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// ante implies cons in the next cycle
`define ICU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ICU_ASSERT_HOLDS(lbl, expr, msg)
`define ICU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ICU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/icu_pkg.sv
// ---------------------------------------------------------------------------
// icu_pkg
// Opcodes and constants of the integer calculator unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package icu_pkg;

	// request opcodes
	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_DIV   = 3'd2,
		OP_MUL   = 3'd3,
		OP_POW   = 3'd4,
		OP_FACT  = 3'd5,
		OP_DEC2  = 3'd6,
		OP_DEC8  = 3'd7
	} op_t;

	localparam int WORD_BITS_DEF = 32;  // internal arithmetic width
	localparam int OPERAND_BITS  = 32;
	localparam int RESULT_BITS   = 32;
	localparam int OP_BITS       = 3;

	localparam int MUL_DIGIT     = 16;  // multiplier bits retired per cycle
	localparam int DEC_RADIX     = 10;
	localparam int DEC_CHUNK     = 8;   // dividend bits per divide-by-ten step
	localparam int REM10_BITS    = 4;   // remainder of a divide by ten
	localparam int BASE2_SHIFT   = 1;
	localparam int BASE8_SHIFT   = 3;

endpackage

### rtl/integer_calculator_unit.sv
// ---------------------------------------------------------------------------
// integer_calculator_unit
// Sequenced integer ALU: add, sub, div, mul, power, factorial, digit convert.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis: tdata = {operand_b, operand_a}, tuser = opcode.
//   One result word leaves on m_axis: tdata = result, tuser = divide-by-zero flag.
//   s_axis_tready is high only while the sequencer is idle; one word in flight.
// Path from accept to m_axis_tvalid (W = WORD_BITS, MD = min(W,16)):
//   add, sub, trivial cases ........ straight to the done state
//   div ............................ one quotient bit per cycle, then the done state
//   mul ............................ one multiply, then the power state hands back the product
//   power .......................... up to 2 multiplies per exponent bit
//   factorial ...................... one multiply per factor, stops once product is 0
//   digit convert .................. divide-by-ten steps of 8 bits, then an accumulate step, per decimal digit
// Mul, power and factorial run through one shared W x MD multiply-accumulate unit; the
//   multiplier operand is retired MD bits per cycle and stops early when the
//   rest of it is zero. This unit and the bit-serial divider set the rate.
// Reset (arst_n low) drops m_axis_tvalid and returns the sequencer to idle.
// The result register decouples the two sides: a new word is accepted while
//   a finished result waits; if m_axis stalls the next result waits in the
//   sequencer until the result register frees up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_calculator_unit #(
	parameter int WORD_BITS = icu_pkg::WORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// slave side
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [31:0] operand_a, [63:32] operand_b
	input  logic [2*icu_pkg::OPERAND_BITS-1:0]      s_axis_tdata,
	// [2:0] req_type
	input  logic [icu_pkg::OP_BITS-1:0]             s_axis_tuser,
	// master side
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// [31:0] result_value
	output logic [icu_pkg::RESULT_BITS-1:0]         m_axis_tdata,
	// [0] div_by_zero
	output logic [0:0]                              m_axis_tuser
);

	localparam int W         = WORD_BITS;
	localparam int OB        = icu_pkg::OPERAND_BITS;
	localparam int RB        = icu_pkg::RESULT_BITS;
	localparam int MD        = (W < icu_pkg::MUL_DIGIT) ? W : icu_pkg::MUL_DIGIT;
	localparam int CHUNK     = icu_pkg::DEC_CHUNK;
	localparam int DIV_STEPS = (W + CHUNK - 1) / CHUNK;
	localparam int DW        = DIV_STEPS * CHUNK;
	localparam int RW        = icu_pkg::REM10_BITS;
	localparam int CNT_W     = $clog2(W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_POW,
		S_FACT,
		S_DIV,
		S_CONV_DIV,
		S_CONV_ACC,
		S_DONE
	} state_t;

	typedef enum logic {
		DST_ACC,
		DST_BASE
	} dst_t;

	state_t          state_q, mul_ret_q;
	dst_t            mul_dst_q;
	icu_pkg::op_t    op_q;

	// shared multiply-accumulate unit
	logic [W-1:0]    mc_q, mp_q, prod_q;
	// power / factorial / conversion working set
	logic [W-1:0]    acc_q, base_q, exp_q, wgt_q;
	logic            sq_q, base8_q;
	// divider
	logic [W-1:0]    rem_q, quo_q, dvs_q;
	logic            neg_q;
	logic [CNT_W-1:0] cnt_q;
	// divide by ten
	logic [DW-1:0]   dv_q;
	logic [RW-1:0]   r10_q;
	// result
	logic [W-1:0]    res_q;
	logic            err_q;
	logic            out_valid_q;
	logic [RB-1:0]   out_data_q;
	logic            out_err_q;

	// input decode
	icu_pkg::op_t    op_in;
	logic [W-1:0]    a_in, b_in, a_abs, b_abs;
	logic            a_np, b_np, accept;

	assign op_in  = icu_pkg::op_t'(s_axis_tuser);
	assign a_in   = W'(signed'(s_axis_tdata[OB-1:0]));
	assign b_in   = W'(signed'(s_axis_tdata[2*OB-1:OB]));
	assign a_abs  = a_in[W-1] ? (W'(0) - a_in) : a_in;
	assign b_abs  = b_in[W-1] ? (W'(0) - b_in) : b_in;
	assign a_np   = (a_in == '0) || a_in[W-1];
	assign b_np   = (b_in == '0) || b_in[W-1];
	assign accept = s_axis_tvalid && s_axis_tready;

	// multiply-accumulate step
	logic [W+MD-1:0] mul_part;
	logic [W-1:0]    mul_sum, mp_next;
	logic            mul_last;

	assign mul_part = mc_q * mp_q[MD-1:0];
	assign mul_sum  = prod_q + mul_part[W-1:0];
	assign mp_next  = mp_q >> MD;
	assign mul_last = (mp_next == '0);

	// restoring divide step
	logic [W:0]      div_sh, div_diff;
	logic            div_ge;
	logic [W-1:0]    rem_n, quo_n;

	assign div_sh   = {rem_q, quo_q[W-1]};
	assign div_diff = div_sh - {1'b0, dvs_q};
	assign div_ge   = !div_diff[W];
	assign rem_n    = div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
	assign quo_n    = {quo_q[W-2:0], div_ge};

	// divide by ten, CHUNK bits per cycle
	logic [RW-1:0]   d10_rem;
	logic [RW:0]     d10_sh;
	logic [CHUNK-1:0] d10_qb;
	logic [DW-1:0]   dv_n;

	always_comb begin
		d10_rem = r10_q;
		d10_qb  = '0;
		d10_sh  = '0;
		for (int k = 0; k < CHUNK; k++) begin
			d10_sh = {d10_rem, dv_q[DW-1-k]};
			if (d10_sh >= (RW+1)'(icu_pkg::DEC_RADIX)) begin
				d10_rem = RW'(d10_sh - (RW+1)'(icu_pkg::DEC_RADIX));
				d10_qb[CHUNK-1-k] = 1'b1;
			end else begin
				d10_rem = d10_sh[RW-1:0];
			end
		end
	end

	assign dv_n = (dv_q << CHUNK) | DW'(d10_qb);

	// digit accumulate
	logic [W+RW-1:0] dig_prod;
	logic [W-1:0]    conv_acc_n, wgt_n;

	assign dig_prod   = r10_q * wgt_q;
	assign conv_acc_n = acc_q + dig_prod[W-1:0];
	assign wgt_n      = base8_q ? (wgt_q << icu_pkg::BASE8_SHIFT)
	                            : (wgt_q << icu_pkg::BASE2_SHIFT);

	logic [RB-1:0]   res_out;
	assign res_out = RB'(signed'(res_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_ret_q   <= S_POW;
			mul_dst_q   <= DST_ACC;
			op_q        <= icu_pkg::OP_ADD;
			mc_q        <= '0;
			mp_q        <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			base_q      <= '0;
			exp_q       <= '0;
			wgt_q       <= '0;
			sq_q        <= 1'b0;
			base8_q     <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			dvs_q       <= '0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			dv_q        <= '0;
			r10_q       <= '0;
			res_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_err_q   <= 1'b0;
		end else begin
			// the done state reloads the result register on its own
			if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= op_in;
						err_q <= 1'b0;
						unique case (op_in)
							icu_pkg::OP_ADD: begin
								res_q   <= a_in + b_in;
								state_q <= S_DONE;
							end
							icu_pkg::OP_SUB: begin
								res_q   <= a_in - b_in;
								state_q <= S_DONE;
							end
							icu_pkg::OP_DIV: begin
								if (b_in == '0) begin
									res_q   <= '0;
									err_q   <= 1'b1;
									state_q <= S_DONE;
								end else begin
									quo_q   <= a_abs;
									dvs_q   <= b_abs;
									rem_q   <= '0;
									neg_q   <= a_in[W-1] ^ b_in[W-1];
									cnt_q   <= '0;
									state_q <= S_DIV;
								end
							end
							icu_pkg::OP_MUL: begin
								// power loop with a zero exponent just hands back acc
								mc_q      <= a_in;
								mp_q      <= b_in;
								prod_q    <= '0;
								mul_dst_q <= DST_ACC;
								mul_ret_q <= S_POW;
								exp_q     <= '0;
								state_q   <= S_MUL;
							end
							icu_pkg::OP_POW: begin
								if (b_np || b_in == W'(1)) begin
									res_q   <= a_in;
									state_q <= S_DONE;
								end else begin
									acc_q   <= W'(1);
									base_q  <= a_in;
									exp_q   <= b_in;
									sq_q    <= 1'b0;
									state_q <= S_POW;
								end
							end
							icu_pkg::OP_FACT: begin
								if (a_np) begin
									res_q   <= W'(1);
									state_q <= S_DONE;
								end else begin
									acc_q   <= W'(1);
									base_q  <= a_in;   // upper factor
									exp_q   <= W'(1);  // next factor
									state_q <= S_FACT;
								end
							end
							icu_pkg::OP_DEC2,
							icu_pkg::OP_DEC8: begin
								if (a_np) begin
									res_q   <= '0;
									state_q <= S_DONE;
								end else begin
									dv_q    <= DW'(a_in);
									r10_q   <= '0;
									cnt_q   <= '0;
									acc_q   <= '0;
									wgt_q   <= W'(1);
									base8_q <= (op_in == icu_pkg::OP_DEC8);
									state_q <= S_CONV_DIV;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_MUL: begin
					prod_q <= mul_sum;
					mc_q   <= mc_q << MD;
					mp_q   <= mp_next;
					if (mul_last) begin
						if (mul_dst_q == DST_ACC) begin
							acc_q <= mul_sum;
						end else begin
							base_q <= mul_sum;
						end
						state_q <= mul_ret_q;
					end
				end

				S_POW: begin
					if (exp_q == '0) begin
						res_q   <= acc_q;
						state_q <= S_DONE;
					end else if (exp_q[0] && !sq_q) begin
						mc_q      <= acc_q;
						mp_q      <= base_q;
						prod_q    <= '0;
						mul_dst_q <= DST_ACC;
						mul_ret_q <= S_POW;
						sq_q      <= 1'b1;
						state_q   <= S_MUL;
					end else if ((exp_q >> 1) == '0) begin
						// last exponent bit done, final square is not needed
						res_q   <= acc_q;
						state_q <= S_DONE;
					end else begin
						mc_q      <= base_q;
						mp_q      <= base_q;
						prod_q    <= '0;
						mul_dst_q <= DST_BASE;
						mul_ret_q <= S_POW;
						exp_q     <= exp_q >> 1;
						sq_q      <= 1'b0;
						state_q   <= S_MUL;
					end
				end

				S_FACT: begin
					if (acc_q == '0 || exp_q > base_q) begin
						res_q   <= acc_q;
						state_q <= S_DONE;
					end else begin
						mc_q      <= acc_q;
						mp_q      <= exp_q;
						prod_q    <= '0;
						mul_dst_q <= DST_ACC;
						mul_ret_q <= S_FACT;
						exp_q     <= exp_q + W'(1);
						state_q   <= S_MUL;
					end
				end

				S_DIV: begin
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(W - 1)) begin
						res_q   <= neg_q ? (W'(0) - quo_n) : quo_n;
						state_q <= S_DONE;
					end
				end

				S_CONV_DIV: begin
					dv_q  <= dv_n;
					r10_q <= d10_rem;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_CONV_ACC;
					end
				end

				S_CONV_ACC: begin
					// dv_q now holds the quotient, r10_q the digit
					acc_q <= conv_acc_n;
					wgt_q <= wgt_n;
					r10_q <= '0;
					cnt_q <= '0;
					if (dv_q[W-1:0] == '0) begin
						res_q   <= conv_acc_n;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CONV_DIV;
					end
				end

				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_out;
						out_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_err_q;

	`include "integer_calculator_unit_assert.svh"

	`ICU_ASSERT_IMPLY(a_err_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "error word carries nonzero data")
	`ICU_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready, "ready after accept")
	`ICU_ASSERT_IMPLY(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "result loaded outside done")
	`ICU_ASSERT_IMPLY(a_err_div_only, state_q == S_DONE && err_q, op_q == icu_pkg::OP_DIV, "error flag on non-divide")
	`ICU_ASSERT_IMPLY(a_mul_return, state_q == S_MUL, mul_ret_q == S_POW || mul_ret_q == S_FACT, "bad multiply return")

endmodule
